// ===== sv/fsfc_pkg.sv =====
// ============================================================================
// fsfc_pkg: shared types, constants and CRC function
// This package holds the result item type, the sizes that follow from the
// search window and the sector size limit, and the byte-wide CCITT CRC step.
// ============================================================================
package fsfc_pkg;

    localparam int unsigned SEARCH_LIMIT  = 80;
    localparam int unsigned MAX_SIZE_CODE = 7;

    // The offset counter must reach SEARCH_LIMIT + 1.
    localparam int unsigned OFS_W = $clog2(SEARCH_LIMIT + 2);
    // The data counter must hold 128 << MAX_SIZE_CODE.
    localparam int unsigned DCNT_W = 8 + MAX_SIZE_CODE;

    localparam logic [15:0] CRC_SEED   = 16'hCDB4;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  ID_MARK    = 8'hFE;
    localparam logic [7:0]  SYNC_BYTE  = 8'hA1;
    localparam logic [7:0]  DATA_MARK  = 8'hFB;
    localparam logic [15:0] SYNC_PAIR  = {SYNC_BYTE, SYNC_BYTE};

    localparam int unsigned IDX_CYL  = 0;
    localparam int unsigned IDX_HEAD = 1;
    localparam int unsigned IDX_SEC  = 2;
    localparam int unsigned IDX_SIZE = 3;

    // One raw track byte with its start flag.
    typedef struct packed {
        logic [7:0] track_byte;
        logic       sector_start;
    } track_item_t;

    // One result item.
    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [7:0] cylinder;
        logic [7:0] head;
        logic [7:0] sector;
        logic [2:0] size_code;
        logic       id_crc_error;
        logic       data_crc_error;
        logic       data_mark_missing;
        logic       last;
    } result_t;

    // CCITT CRC, MSB first, advanced by one byte.
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15] ^ b[7])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
            b = {b[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// ===== sv/fsfc_in_stage.sv =====
// ============================================================================
// fsfc_in_stage: input register
// Holds one track byte request until the checker core takes it.
// ============================================================================
module fsfc_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsfc_pkg::track_item_t s_item,
    output logic                  item_valid,
    output fsfc_pkg::track_item_t item,
    input  logic                  item_take
);

    logic                  valid_reg;
    logic                  valid_next;
    fsfc_pkg::track_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/fsfc_core.sv =====
// ============================================================================
// fsfc_core: sector field state machine
// Walks the ID field, searches for the data mark, forwards the data bytes
// and builds the status item, with a byte-wide CRC update per request.
// ============================================================================
module fsfc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  fsfc_pkg::track_item_t item,
    output logic                  item_take,
    input  logic                  res_space,
    output logic                  res_push,
    output fsfc_pkg::result_t     res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_SEARCH,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    phase_t                        phase_reg,   phase_next;
    logic [fsfc_pkg::OFS_W-1:0]    ofs_reg,     ofs_next;
    logic [fsfc_pkg::DCNT_W-1:0]   dcnt_reg,    dcnt_next;
    logic [15:0]                   crc_reg,     crc_next;
    logic [15:0]                   recent_reg,  recent_next;
    logic [7:0]                    id_reg [4];
    logic [7:0]                    id_next [4];
    logic                          id_bad_reg,  id_bad_next;
    logic [7:0]                    crc_hi_reg,  crc_hi_next;

    logic [7:0]  byte_in;
    logic [2:0]  eff_size;
    logic [15:0] crc_step;
    logic [15:0] disk_crc;

    assign item_take = item_valid && res_space;
    assign byte_in   = item.track_byte;
    assign crc_step  = fsfc_pkg::crc_update(crc_reg, byte_in);
    assign disk_crc  = {crc_hi_reg, byte_in};
    assign eff_size  = (id_reg[fsfc_pkg::IDX_SIZE] > 8'(fsfc_pkg::MAX_SIZE_CODE))
                     ? 3'(fsfc_pkg::MAX_SIZE_CODE) : id_reg[fsfc_pkg::IDX_SIZE][2:0];

    always_comb
    begin
        phase_next  = phase_reg;
        ofs_next    = ofs_reg;
        dcnt_next   = dcnt_reg;
        crc_next    = crc_reg;
        recent_next = recent_reg;
        id_next     = id_reg;
        id_bad_next = id_bad_reg;
        crc_hi_next = crc_hi_reg;
        res_push    = 1'b0;
        res         = '0;

        if (item_take)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.sector_start && byte_in == fsfc_pkg::ID_MARK)
                    begin
                        crc_next    = fsfc_pkg::crc_update(fsfc_pkg::CRC_SEED,
                                                           fsfc_pkg::ID_MARK);
                        ofs_next    = fsfc_pkg::OFS_W'(1);
                        recent_next = '0;
                        id_bad_next = 1'b0;
                        phase_next  = PH_ID;
                    end
                end
                PH_ID:
                begin
                    if (ofs_reg >= fsfc_pkg::OFS_W'(1) && ofs_reg <= fsfc_pkg::OFS_W'(4))
                    begin
                        id_next[2'(ofs_reg - fsfc_pkg::OFS_W'(1))] = byte_in;
                        crc_next = crc_step;
                    end
                    else if (ofs_reg == fsfc_pkg::OFS_W'(5))
                    begin
                        crc_hi_next = byte_in;
                    end
                    else
                    begin
                        id_bad_next = (disk_crc != crc_reg);
                        phase_next  = PH_SEARCH;
                    end
                    ofs_next = ofs_reg + fsfc_pkg::OFS_W'(1);
                end
                PH_SEARCH:
                begin
                    if (ofs_reg >= fsfc_pkg::OFS_W'(9) && recent_reg == fsfc_pkg::SYNC_PAIR
                        && byte_in == fsfc_pkg::DATA_MARK)
                    begin
                        crc_next   = fsfc_pkg::crc_update(fsfc_pkg::CRC_SEED,
                                                          fsfc_pkg::DATA_MARK);
                        dcnt_next  = fsfc_pkg::DCNT_W'(128) << eff_size;
                        phase_next = PH_DATA;
                    end
                    else if (ofs_reg >= fsfc_pkg::OFS_W'(fsfc_pkg::SEARCH_LIMIT + 1))
                    begin
                        // Window exhausted without a data mark.
                        res_push              = 1'b1;
                        res.is_status         = 1'b1;
                        res.cylinder          = id_reg[fsfc_pkg::IDX_CYL];
                        res.head              = id_reg[fsfc_pkg::IDX_HEAD];
                        res.sector            = id_reg[fsfc_pkg::IDX_SEC];
                        res.size_code         = eff_size;
                        res.id_crc_error      = id_bad_reg;
                        res.data_crc_error    = 1'b1;
                        res.data_mark_missing = 1'b1;
                        res.last              = 1'b1;
                        phase_next            = PH_IDLE;
                    end
                    else
                    begin
                        recent_next = {recent_reg[7:0], byte_in};
                        ofs_next    = ofs_reg + fsfc_pkg::OFS_W'(1);
                    end
                end
                PH_DATA:
                begin
                    crc_next      = crc_step;
                    res_push      = 1'b1;
                    res.data_byte = byte_in;
                    dcnt_next     = dcnt_reg - fsfc_pkg::DCNT_W'(1);
                    if (dcnt_reg == fsfc_pkg::DCNT_W'(1))
                    begin
                        phase_next = PH_CRC_HI;
                    end
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = byte_in;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    res_push              = 1'b1;
                    res.is_status         = 1'b1;
                    res.cylinder          = id_reg[fsfc_pkg::IDX_CYL];
                    res.head              = id_reg[fsfc_pkg::IDX_HEAD];
                    res.sector            = id_reg[fsfc_pkg::IDX_SEC];
                    res.size_code         = eff_size;
                    res.id_crc_error      = id_bad_reg;
                    res.data_crc_error    = (disk_crc != crc_reg);
                    res.data_mark_missing = 1'b0;
                    res.last              = 1'b1;
                    phase_next            = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ofs_reg    <= '0;
            dcnt_reg   <= '0;
            crc_reg    <= fsfc_pkg::CRC_SEED;
            recent_reg <= '0;
            id_reg     <= '{default: 8'h00};
            id_bad_reg <= 1'b0;
            crc_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ofs_reg    <= ofs_next;
            dcnt_reg   <= dcnt_next;
            crc_reg    <= crc_next;
            recent_reg <= recent_next;
            id_reg     <= id_next;
            id_bad_reg <= id_bad_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

    // A status item always closes the sector.
    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.is_status) |=> (phase_reg == PH_IDLE))
        else $error("phase did not return to idle after a status item");

    // Data bytes flow only while the byte count is still running.
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.is_status) |-> (dcnt_reg != '0))
        else $error("data byte emitted with an empty byte count");

    // Entering the data phase loads a nonzero length.
    a_data_load: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(phase_reg) == PH_SEARCH && phase_reg == PH_DATA) |-> (dcnt_reg != '0))
        else $error("data phase entered with a zero length");

    // The search never runs past the end of its window.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |-> (ofs_reg <= fsfc_pkg::OFS_W'(fsfc_pkg::SEARCH_LIMIT + 1)))
        else $error("search offset ran past the window");

endmodule

// ===== sv/fsfc_out_buf.sv =====
// ============================================================================
// fsfc_out_buf: two-entry result buffer
// Registers result items so the core keeps working while the sink stalls.
// ============================================================================
module fsfc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fsfc_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output fsfc_pkg::result_t m_data
);

    fsfc_pkg::result_t mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg,  count_next;
    logic              pop;

    assign space   = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("result pushed into a full buffer");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer pointers disagree with the fill count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("buffer fill count out of range");

endmodule

// ===== sv/floppy_sector_field_checker_unit.sv =====
// ============================================================================
// floppy_sector_field_checker_unit: MFM sector ID and data CRC checker
// Parses raw track bytes into sector data bytes and one status item per sector.
// ============================================================================
// When the sink keeps up, the unit takes one raw track byte per cycle and
// delivers one result per cycle. A byte is registered in an input register,
// and its result is registered in a two-entry result buffer, from which it is
// presented on the output.
// The CRC update is one byte-wide step in the core, which sets the cycle time.
// A byte flagged as a sector start that equals FE opens a
// sector: the next four bytes are C, H, R and N, followed by the ID CRC, high
// byte first. The unit then searches for A1 A1 FB, with the first A1 at
// offset 7 up to SEARCH_LIMIT-1 from the ID mark, forwards the 128 << N data
// bytes (N saturated at MAX_SIZE_CODE) and checks the data CRC over FB and
// the data against the two bytes that follow. Each sector ends with a status
// request carrying C, H, R, N and the error flags, with tlast high. If the
// data mark never shows up, the status request is sent on the byte at offset
// SEARCH_LIMIT+1 with the missing-mark and data CRC error flags set. Start
// flags on other bytes, or while a sector is in progress, are ignored.
// ============================================================================
module floppy_sector_field_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] track_byte
    input  logic        s_tuser,   // [0] sector_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] cylinder, [23:16] head, [31:24] sector,
    // [34:32] size_code, [35] id_crc_error, [36] data_crc_error,
    // [37] data_mark_missing, [39:38] zero
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // [0] is_status
    output logic        m_tlast
);

    fsfc_pkg::track_item_t s_item;
    fsfc_pkg::track_item_t item;
    fsfc_pkg::result_t     res;
    fsfc_pkg::result_t     out_res;
    logic                  item_valid;
    logic                  item_take;
    logic                  res_space;
    logic                  res_push;

    assign s_item.track_byte   = s_tdata;
    assign s_item.sector_start = s_tuser;

    // Input register: holds the byte until the core can process it.
    fsfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Core: sector state machine and CRC check, one byte per cycle while the result buffer has space.
    fsfc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_space  (res_space),
        .res_push   (res_push),
        .res        (res)
    );

    // Result buffer: decouples the core from a stalling sink.
    fsfc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .space     (res_space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res)
    );

    assign m_tdata = {2'b00,
                      out_res.data_mark_missing,
                      out_res.data_crc_error,
                      out_res.id_crc_error,
                      out_res.size_code,
                      out_res.sector,
                      out_res.head,
                      out_res.cylinder,
                      out_res.data_byte};
    assign m_tuser = out_res.is_status;
    assign m_tlast = out_res.last;

endmodule

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb: self-checking bench for the floppy sector field checker
// Builds MFM-style track streams (good sectors, bad CRCs, missing or
// misplaced data marks, saturated size codes and plain noise) and drives
// them through the stream ports with random gaps on both sides. A scoreboard
// predicts every data byte and status request and checks them in order.
// ============================================================================
module tb;

    // Ways in which the data address mark of a generated sector is laid out.
    typedef enum int {
        MARK_GOOD,    // A1 A1 FB inside the window, data and CRC follow
        MARK_NONE,    // no mark at all, the window runs out
        MARK_LATE,    // A1 A1 at offsets 80 and 81, one byte too late
        MARK_EARLY,   // A1 A1 in the ID CRC slot and FB at offset 7
        MARK_BROKEN   // partial sync patterns that must not be taken
    } mark_kind_t;

    // States of the sector parser as the scoreboard tracks it.
    typedef enum logic [2:0] {
        WAIT_MARK,
        READ_ID,
        HUNT_DAM,
        PASS_DATA,
        DCRC_HI,
        DCRC_LO
    } scan_t;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_LEN    = 400;
    localparam int TAIL_CYCLES = 8;
    localparam int ITEM_TARGET = 1600;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the byte stream, queues the sector results that
    // each accepted byte causes, and checks result requests against them.
    // ------------------------------------------------------------------------
    class sector_scoreboard;
        scan_t                       mode;
        logic [fsfc_pkg::OFS_W-1:0]  ofs;
        logic [fsfc_pkg::DCNT_W-1:0] left;
        logic [15:0]                 crc;
        logic [15:0]                 last_two;
        logic [7:0]                  chrn [4];
        logic                        id_bad;
        logic [7:0]                  hi_byte;
        fsfc_pkg::result_t           sector_q [$];
        int                          errors;
        int                          data_seen;
        int                          status_seen;

        function new();
            mode        = WAIT_MARK;
            ofs         = '0;
            left        = '0;
            crc         = fsfc_pkg::CRC_SEED;
            last_two    = '0;
            for (int i = 0; i < 4; i++)
            begin
                chrn[i] = '0;
            end
            id_bad      = 1'b0;
            hi_byte     = '0;
            errors      = 0;
            data_seen   = 0;
            status_seen = 0;
        endfunction

        // CCITT step, one data bit at a time from the top.
        function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] d);
            logic [15:0] a;
            logic        fb;
            a = acc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = a[15] ^ d[i];
                a  = {a[14:0], 1'b0};
                if (fb)
                begin
                    a = a ^ fsfc_pkg::CRC_POLY;
                end
            end
            return a;
        endfunction

        function logic [2:0] size_eff();
            if (chrn[fsfc_pkg::IDX_SIZE] > fsfc_pkg::MAX_SIZE_CODE)
            begin
                return 3'(fsfc_pkg::MAX_SIZE_CODE);
            end
            return chrn[fsfc_pkg::IDX_SIZE][2:0];
        endfunction

        function fsfc_pkg::result_t status_of(logic data_bad, logic missing);
            fsfc_pkg::result_t r;
            r                   = '0;
            r.is_status         = 1'b1;
            r.cylinder          = chrn[fsfc_pkg::IDX_CYL];
            r.head              = chrn[fsfc_pkg::IDX_HEAD];
            r.sector            = chrn[fsfc_pkg::IDX_SEC];
            r.size_code         = size_eff();
            r.id_crc_error      = id_bad;
            r.data_crc_error    = data_bad;
            r.data_mark_missing = missing;
            r.last              = 1'b1;
            return r;
        endfunction

        // Advances the parser by one accepted track byte.
        function void note_byte(logic [7:0] b, logic st);
            fsfc_pkg::result_t r;
            r = '0;
            case (mode)
                WAIT_MARK:
                begin
                    // Only a flagged FE opens a sector; anything else is skipped.
                    if (st && b == fsfc_pkg::ID_MARK)
                    begin
                        crc      = crc_byte(fsfc_pkg::CRC_SEED, fsfc_pkg::ID_MARK);
                        ofs      = 1;
                        last_two = '0;
                        id_bad   = 1'b0;
                        mode     = READ_ID;
                    end
                end
                READ_ID:
                begin
                    if (ofs >= 1 && ofs <= 4)
                    begin
                        chrn[ofs[1:0] - 2'd1] = b;
                        crc = crc_byte(crc, b);
                    end
                    else if (ofs == 5)
                    begin
                        hi_byte = b;
                    end
                    else
                    begin
                        id_bad = ({hi_byte, b} != crc);
                        mode   = HUNT_DAM;
                    end
                    ofs++;
                end
                HUNT_DAM:
                begin
                    if (ofs >= 9 && last_two == fsfc_pkg::SYNC_PAIR
                        && b == fsfc_pkg::DATA_MARK)
                    begin
                        crc  = crc_byte(fsfc_pkg::CRC_SEED, fsfc_pkg::DATA_MARK);
                        left = fsfc_pkg::DCNT_W'(128 << size_eff());
                        mode = PASS_DATA;
                    end
                    else if (ofs >= fsfc_pkg::SEARCH_LIMIT + 1)
                    begin
                        // The window ran out: report the mark as missing.
                        sector_q.push_back(status_of(1'b1, 1'b1));
                        mode = WAIT_MARK;
                    end
                    else
                    begin
                        last_two = {last_two[7:0], b};
                        ofs++;
                    end
                end
                PASS_DATA:
                begin
                    crc         = crc_byte(crc, b);
                    r.data_byte = b;
                    sector_q.push_back(r);
                    left--;
                    if (left == 0)
                    begin
                        mode = DCRC_HI;
                    end
                end
                DCRC_HI:
                begin
                    hi_byte = b;
                    mode    = DCRC_LO;
                end
                default:
                begin
                    sector_q.push_back(status_of({hi_byte, b} != crc, 1'b0));
                    mode = WAIT_MARK;
                end
            endcase
        endfunction

        function void field_check(string name, logic [7:0] exp, logic [7:0] act);
            if (exp !== act)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, exp, act);
                errors++;
            end
        endfunction

        // Compares one accepted result request with the oldest prediction.
        function void check_result(logic [39:0] d, logic u, logic l);
            fsfc_pkg::result_t e;
            if (sector_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, %s",
                         $time, "got a result request");
                $display("%0t: got tdata=%h tuser=%b tlast=%b", $time, d, u, l);
                errors++;
                return;
            end
            e = sector_q.pop_front();
            if (u)
            begin
                status_seen++;
            end
            else
            begin
                data_seen++;
            end
            field_check("is_status", 8'(e.is_status), 8'(u));
            field_check("data_byte", e.data_byte, d[7:0]);
            field_check("cylinder", e.cylinder, d[15:8]);
            field_check("head", e.head, d[23:16]);
            field_check("sector", e.sector, d[31:24]);
            field_check("size_code", 8'(e.size_code), 8'(d[34:32]));
            field_check("id_crc_error", 8'(e.id_crc_error), 8'(d[35]));
            field_check("data_crc_error", 8'(e.data_crc_error), 8'(d[36]));
            field_check("data_mark_missing", 8'(e.data_mark_missing), 8'(d[37]));
            field_check("pad", 8'h00, 8'(d[39:38]));
            field_check("last", 8'(e.last), 8'(l));
        endfunction

        function int outstanding();
            return sector_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sector_scoreboard sb = new();

    bit calm = 1'b0;          // no idling on either side while set
    int hold_cycles = 0;      // receiver hold-off still to go
    int items_sent = 0;
    int sectors_sent = 0;
    int quiet_cycles = 0;

    floppy_sector_field_checker_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random back-pressure, or a long hold-off when one is asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // Every result request goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog: too many cycles without any request moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results still expected",
                         $time, quiet_cycles, sb.outstanding());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offers one track byte and waits until the unit takes it.
    task automatic send_track_byte(input fsfc_pkg::track_item_t it);
        while (!calm && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.track_byte;
        s_tuser  <= it.sector_start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_byte(it.track_byte, it.sector_start);
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering bytes until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] gap_fill();
        logic [7:0] v;
        case ($urandom_range(3))
            0: v = 8'h4E;
            1: v = 8'h00;
            default:
            begin
                v = 8'($urandom);
                if (v == fsfc_pkg::SYNC_BYTE || v == fsfc_pkg::DATA_MARK)
                begin
                    v = 8'h4E;
                end
            end
        endcase
        return v;
    endfunction

    // Builds one sector, from its ID mark to its data CRC, and sends it.
    // The gap sets where the first A1 lands: offset 7 plus the gap.
    task automatic send_sector(input logic [7:0] c, input logic [7:0] h,
                               input logic [7:0] r, input logic [7:0] n,
                               input int gap, input mark_kind_t kind,
                               input bit bad_id, input bit bad_data,
                               input bit squeeze);
        fsfc_pkg::track_item_t q [$];
        logic [15:0] id_crc;
        logic [15:0] dat_crc;
        logic [7:0]  d;
        int          len;
        int          data_at;
        data_at = -1;
        id_crc  = sb.crc_byte(fsfc_pkg::CRC_SEED, fsfc_pkg::ID_MARK);
        id_crc  = sb.crc_byte(id_crc, c);
        id_crc  = sb.crc_byte(id_crc, h);
        id_crc  = sb.crc_byte(id_crc, r);
        id_crc  = sb.crc_byte(id_crc, n);
        if (bad_id)
        begin
            id_crc = id_crc ^ (16'h0001 << $urandom_range(15));
        end
        q.push_back('{fsfc_pkg::ID_MARK, 1'b1});
        // A stray start flag inside the ID field must be ignored.
        q.push_back('{c, 1'($urandom_range(9) == 0)});
        q.push_back('{h, 1'b0});
        q.push_back('{r, 1'($urandom_range(9) == 0)});
        q.push_back('{n, 1'b0});
        if (kind == MARK_EARLY)
        begin
            q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
            q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
        end
        else
        begin
            q.push_back('{id_crc[15:8], 1'b0});
            q.push_back('{id_crc[7:0], 1'b0});
        end
        case (kind)
            MARK_GOOD:
            begin
                repeat (gap) q.push_back('{gap_fill(), 1'b0});
                q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
                q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
                q.push_back('{fsfc_pkg::DATA_MARK, 1'b0});
                data_at = q.size();
                len     = 128 << ((n > fsfc_pkg::MAX_SIZE_CODE)
                                  ? fsfc_pkg::MAX_SIZE_CODE : n);
                dat_crc = sb.crc_byte(fsfc_pkg::CRC_SEED, fsfc_pkg::DATA_MARK);
                repeat (len)
                begin
                    d       = 8'($urandom);
                    dat_crc = sb.crc_byte(dat_crc, d);
                    // Start flags, FE bytes among them, are ignored in the data.
                    q.push_back('{d, 1'($urandom_range(15) == 0)});
                end
                if (bad_data)
                begin
                    dat_crc = dat_crc ^ (16'h0001 << $urandom_range(15));
                end
                q.push_back('{dat_crc[15:8], 1'b0});
                q.push_back('{dat_crc[7:0], 1'b0});
            end
            MARK_EARLY:
            begin
                // FB right after A1 A1 in the CRC slot is still too early.
                q.push_back('{fsfc_pkg::DATA_MARK, 1'b0});
                repeat (74) q.push_back('{gap_fill(), 1'b0});
            end
            MARK_LATE:
            begin
                repeat (73) q.push_back('{gap_fill(), 1'b0});
                q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
                q.push_back('{fsfc_pkg::SYNC_BYTE, 1'b0});
                q.push_back('{fsfc_pkg::DATA_MARK, 1'b0});
            end
            MARK_BROKEN:
            begin
                repeat (75) q.push_back('{gap_fill(), 1'b0});
                q[10] = '{fsfc_pkg::SYNC_BYTE, 1'b0};
                q[11] = '{fsfc_pkg::SYNC_BYTE, 1'b0};
                q[12] = '{8'h00, 1'b0};
                q[30] = '{fsfc_pkg::SYNC_BYTE, 1'b0};
                q[31] = '{fsfc_pkg::DATA_MARK, 1'b0};
                q[50] = '{fsfc_pkg::SYNC_BYTE, 1'b0};
                q[51] = '{8'h4E, 1'b0};
                q[52] = '{fsfc_pkg::DATA_MARK, 1'b0};
            end
            default:
            begin
                repeat (75) q.push_back('{gap_fill(), 1'b0});
            end
        endcase
        foreach (q[k])
        begin
            if (squeeze && k == data_at + 16)
            begin
                hold_cycles = HOLD_LEN;
            end
            send_track_byte(q[k]);
        end
        sectors_sent++;
    endtask

    // Stray bytes between sectors; a flag on a non-FE byte must be ignored.
    task automatic send_noise(input int count);
        fsfc_pkg::track_item_t it;
        repeat (count)
        begin
            it.track_byte   = 8'($urandom);
            it.sector_start = ($urandom_range(3) == 0)
                              && (it.track_byte != fsfc_pkg::ID_MARK);
            send_track_byte(it);
        end
    endtask

    initial
    begin
        int         pick;
        int         sz;
        int         idx;
        logic [7:0] n_code;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: ignored starts, both ends of the search window,
        // bad CRCs, misplaced marks and a saturated size code, which is
        // checked on a sector without a data mark to keep the run short.
        send_track_byte('{fsfc_pkg::ID_MARK, 1'b0});
        send_track_byte('{8'h00, 1'b1});
        send_track_byte('{8'hFF, 1'b1});
        send_track_byte('{fsfc_pkg::SYNC_BYTE, 1'b1});
        send_sector(8'h00, 8'h00, 8'h01, 8'h00, 0, MARK_GOOD, 1'b0, 1'b0, 1'b0);
        send_sector(8'hFF, 8'hFF, 8'hFF, 8'h01, 72, MARK_GOOD, 1'b0, 1'b1, 1'b1);
        send_sector(8'h27, 8'h01, 8'h09, 8'h00, 20, MARK_GOOD, 1'b1, 1'b0, 1'b0);
        send_sector(8'h05, 8'h00, 8'h03, 8'h02, 0, MARK_NONE, 1'b0, 1'b0, 1'b0);
        send_sector(8'h10, 8'h01, 8'h04, 8'h00, 0, MARK_LATE, 1'b1, 1'b0, 1'b0);
        send_sector(8'h11, 8'h00, 8'h05, 8'h00, 0, MARK_EARLY, 1'b0, 1'b0, 1'b0);
        send_sector(8'h12, 8'h01, 8'h06, 8'h07, 0, MARK_BROKEN, 1'b0, 1'b0, 1'b0);
        send_sector(8'h4F, 8'h01, 8'h12, 8'hFF, 0, MARK_NONE, 1'b0, 1'b0, 1'b0);
        drain_results();

        // Random part: mostly well-formed sectors of the two smallest sizes,
        // the rest broken marks and noise; any size code may appear where
        // no data follows.
        idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (idx >= 1 && idx < 3);
            send_noise($urandom_range(0, 6));
            sz = $urandom_range(99);
            if (sz < 75)
            begin
                n_code = 8'h00;
            end
            else if (sz < 97)
            begin
                n_code = 8'h01;
            end
            else
            begin
                n_code = 8'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_sector(8'($urandom), 8'($urandom), 8'($urandom),
                            (n_code > 8'h01) ? 8'h01 : n_code,
                            $urandom_range(0, 72), MARK_GOOD,
                            $urandom_range(99) < 15, $urandom_range(99) < 15, 1'b0);
            end
            else if (pick < 70)
            begin
                send_sector(8'($urandom), 8'($urandom), 8'($urandom), n_code,
                            0, MARK_NONE, $urandom_range(99) < 15, 1'b0, 1'b0);
            end
            else if (pick < 78)
            begin
                send_sector(8'($urandom), 8'($urandom), 8'($urandom), n_code,
                            0, MARK_BROKEN, $urandom_range(99) < 15, 1'b0, 1'b0);
            end
            else if (pick < 83)
            begin
                send_sector(8'($urandom), 8'($urandom), 8'($urandom), n_code,
                            0, MARK_LATE, 1'b0, 1'b0, 1'b0);
            end
            else if (pick < 88)
            begin
                send_sector(8'($urandom), 8'($urandom), 8'($urandom), n_code,
                            0, MARK_EARLY, 1'b0, 1'b0, 1'b0);
            end
            else
            begin
                send_noise($urandom_range(10, 30));
            end
            idx++;
            if (idx == 3)
            begin
                drain_results();
            end
        end
        calm = 1'b0;
        drain_results();

        $display("Sent %0d track bytes in %0d sectors plus noise and stray start flags",
                 items_sent, sectors_sent);
        $display("Checked %0d data bytes and %0d status requests", sb.data_seen,
                 sb.status_seen);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== floppy_sector_field_checker_unit.f =====
sv/fsfc_pkg.sv
sv/fsfc_in_stage.sv
sv/fsfc_core.sv
sv/fsfc_out_buf.sv
sv/floppy_sector_field_checker_unit.sv
tb/sv/tb.sv
